/* sv/nlpw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlpw_pkg
// Shared types and constants for the pixel pair weight terms unit.
// ----------------------------------------------------------------------------
package nlpw_pkg;

  // Widths cover the smallest supported fraction width (8 bits).
  localparam int NUM_W = 57;  // signed numerator
  localparam int DEN_W = 56;  // unsigned denominator
  localparam int MAG_W = 56;  // numerator magnitude

  localparam logic [2:0] REG_KC  = 3'd0;
  localparam logic [2:0] REG_KF  = 3'd1;
  localparam logic [2:0] REG_TR  = 3'd2;
  localparam logic [2:0] REG_TB  = 3'd3;
  localparam logic [2:0] REG_EPS = 3'd4;

  localparam logic TYPE_COLOR = 1'b0;
  localparam logic TYPE_FEAT  = 1'b1;

  typedef struct packed {
    logic [30:0] kc;
    logic [30:0] kf;
    logic [30:0] tau_r;
    logic [30:0] tau_b;
    logic [30:0] eps;
  } cfg_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic                    typ;
    logic                    last;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den0;
    logic [DEN_W-1:0]        den1;
  } entry_t;

  typedef enum logic [1:0] {FE_IDLE, FE_MUL, FE_PUSH} fe_state_t;
  typedef enum logic [1:0] {BK_IDLE, BK_DIV0, BK_DIV1, BK_EMIT} bk_state_t;

endpackage

/* sv/nlpw_fe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlpw_fe
// Front end: accepts an item, forms the numerator and both denominators.
// ----------------------------------------------------------------------------
module nlpw_fe
  import nlpw_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_val_p,
  input  logic [31:0] in_val_q,
  input  logic [30:0] in_var_p,
  input  logic [30:0] in_var_q,
  input  logic [30:0] in_gradient,
  input  logic        in_last,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_data
);

  fe_state_t state_r, state_nxt;

  logic        typ_r, last_r;
  logic [31:0] absd_r, vsum_r, vpm_r;
  logic [30:0] nr_r, nb_r;
  entry_t      ent_r;

  logic signed [32:0] diff;
  logic [31:0]        absd;
  logic [30:0]        vmin, vmax, nr, nb;
  logic [63:0]        sq_full, p0_full, p1_full;
  logic [63:0]        sq, p0, p1;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]   den0;

  always_comb begin
    diff = 33'(signed'(in_val_p)) - 33'(signed'(in_val_q));
    absd = diff[32] ? 32'(-diff) : diff[31:0];
    vmin = (in_var_p < in_var_q) ? in_var_p : in_var_q;
    vmax = (in_var_p > in_gradient) ? in_var_p : in_gradient;
    nr   = (cfg.tau_r > vmax) ? cfg.tau_r : vmax;
    nb   = (cfg.tau_b > vmax) ? cfg.tau_b : vmax;
  end

  always_comb begin
    sq_full = 64'(absd_r) * 64'(absd_r);
    sq      = sq_full >> FRAC_BITS;
    num     = NUM_W'(signed'({1'b0, vpm_r})) - NUM_W'(signed'({1'b0, sq}));
    if (typ_r == TYPE_COLOR) begin
      p0_full = 64'(cfg.kc) * 64'(vsum_r);
      p0      = p0_full >> FRAC_BITS;
      den0    = DEN_W'(p0) + DEN_W'(cfg.eps);
    end else begin
      p0_full = 64'(cfg.kf) * 64'(nr_r);
      p0      = p0_full >> FRAC_BITS;
      den0    = DEN_W'(p0);
    end
    p1_full = 64'(cfg.kf) * 64'(nb_r);
    p1      = p1_full >> FRAC_BITS;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: if (in_valid) state_nxt = FE_MUL;
      FE_MUL:  state_nxt = FE_PUSH;
      FE_PUSH: if (!q_full) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != FE_IDLE);
    q_push   = (state_r == FE_PUSH) && !q_full;
    q_data   = ent_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FE_IDLE && in_valid) begin
      typ_r  <= in_req_type;
      last_r <= in_last;
      absd_r <= absd;
      vsum_r <= 32'(in_var_p) + 32'(in_var_q);
      vpm_r  <= 32'(in_var_p) + 32'(vmin);
      nr_r   <= nr;
      nb_r   <= nb;
    end
    if (state_r == FE_MUL) begin
      ent_r.typ  <= typ_r;
      ent_r.last <= last_r;
      ent_r.num  <= num;
      ent_r.den0 <= den0;
      ent_r.den1 <= DEN_W'(p1);
    end
  end

endmodule

/* sv/nlpw_q.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlpw_q
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module nlpw_q
  import nlpw_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  entry_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

/* sv/nlpw_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlpw_div
// Bit-serial saturating divider: num * 2^FRAC_BITS / den, toward zero.
// ----------------------------------------------------------------------------
module nlpw_div
  import nlpw_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic                    done,
  output logic [31:0]             result
);

  logic             busy_r, done_r, neg_r, ovf_r, zero_r;
  logic [5:0]       cnt_r;
  logic [DEN_W:0]   rem_r;
  logic [31:0]      low_r, quo_r, res_r;
  logic [DEN_W-1:0] den_r;

  logic [MAG_W-1:0] mag;
  logic [63:0]      dvd;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [31:0]      fin;
  logic             finish;

  always_comb begin
    mag    = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    dvd    = 64'(mag) << FRAC_BITS;
    rem_sh = {rem_r[DEN_W-1:0], low_r[31]};
    ge     = (rem_sh >= {1'b0, den_r});
    finish = (cnt_r == 6'd0) || ovf_r || zero_r;
    if (zero_r) begin
      fin = 32'd0;
    end else if (neg_r) begin
      fin = (ovf_r || quo_r > 32'h8000_0000) ? 32'h8000_0000 : -quo_r;
    end else begin
      fin = (ovf_r || quo_r[31]) ? 32'h7FFF_FFFF : quo_r;
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start || (busy_r && !finish);
      done_r <= !start && busy_r && finish;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= num[NUM_W-1];
      zero_r <= (mag == '0);
      ovf_r  <= ({25'd0, dvd[63:32]} >= {1'b0, den});
      rem_r  <= {25'd0, dvd[63:32]};
      low_r  <= dvd[31:0];
      den_r  <= den;
      quo_r  <= 32'd0;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      if (finish) begin
        res_r <= fin;
      end else begin
        rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
        low_r <= {low_r[30:0], 1'b0};
        quo_r <= {quo_r[30:0], ge};
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

endmodule

/* sv/nlpw_be.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlpw_be
// Back end: divides each queued item, accumulates, and emits on last.
// ----------------------------------------------------------------------------
module nlpw_be
  import nlpw_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  entry_t      q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_color_term,
  output logic [31:0] out_feature_r,
  output logic [31:0] out_feature_b
);

  bk_state_t state_r, state_nxt;
  entry_t    ent_r;
  logic signed [31:0] csum_r, fmin_r_r, fmin_b_r;
  logic        oval_r;
  logic [31:0] oc_r, ofr_r, ofb_r;

  logic                    div_start, div_busy, div_done;
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic [31:0]             div_res;
  logic signed [32:0]      csum_add;
  logic signed [31:0]      csum_sat;
  logic                    out_free;

  nlpw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .busy   (div_busy),
    .done   (div_done),
    .result (div_res)
  );

  always_comb begin
    csum_add = 33'(csum_r) + 33'(signed'(div_res));
    if (csum_add > 33'sd2147483647)       csum_sat = 32'sh7FFF_FFFF;
    else if (csum_add < -33'sd2147483648) csum_sat = 32'sh8000_0000;
    else                                  csum_sat = csum_add[31:0];
    out_free = !oval_r || !out_stall;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_DIV0;
      BK_DIV0: begin
        if (div_done) begin
          if (ent_r.typ == TYPE_FEAT) state_nxt = BK_DIV1;
          else if (ent_r.last)        state_nxt = BK_EMIT;
          else                        state_nxt = BK_IDLE;
        end
      end
      BK_DIV1: if (div_done) state_nxt = ent_r.last ? BK_EMIT : BK_IDLE;
      BK_EMIT: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == BK_IDLE) && !q_empty;
    div_start = q_pop ||
                (state_r == BK_DIV0 && div_done && ent_r.typ == TYPE_FEAT);
    div_num   = q_pop ? q_data.num : ent_r.num;
    div_den   = q_pop ? q_data.den0 : ent_r.den1;
  end

  assign out_valid      = oval_r;
  assign out_color_term = oc_r;
  assign out_feature_r  = ofr_r;
  assign out_feature_b  = ofb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      oval_r   <= 1'b0;
      csum_r   <= '0;
      fmin_r_r <= '0;
      fmin_b_r <= '0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= (state_r == BK_EMIT && out_free) || (oval_r && out_stall);
      if (state_r == BK_DIV0 && div_done) begin
        if (ent_r.typ == TYPE_COLOR) csum_r <= csum_sat;
        else if (signed'(div_res) < fmin_r_r) fmin_r_r <= div_res;
      end
      if (state_r == BK_DIV1 && div_done && signed'(div_res) < fmin_b_r) begin
        fmin_b_r <= div_res;
      end
      if (state_r == BK_EMIT && out_free) begin
        csum_r   <= '0;
        fmin_r_r <= '0;
        fmin_b_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) ent_r <= q_data;
    if (state_r == BK_EMIT && out_free) begin
      oc_r  <= csum_r;
      ofr_r <= fmin_r_r;
      ofb_r <= fmin_b_r;
    end
  end

  a_min_r_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    fmin_r_r[31] || fmin_r_r == 32'd0) else $error("feature_r minimum above zero");
  a_min_b_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    fmin_b_r[31] || fmin_b_r == 32'd0) else $error("feature_b minimum above zero");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_div1_feat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV1 |-> ent_r.typ == TYPE_FEAT) else $error("second divide on color item");

endmodule

/* sv/nlmeans_pair_weight_terms_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlmeans_pair_weight_terms_unit
// Non-local-means dissimilarity terms for one pixel pair, in fixed point.
// ----------------------------------------------------------------------------
// The front end forms the numerator and denominators of one item at a time
// and takes no new item until it has pushed the last into a two-entry queue.
// The back end's bit-serial divider sets the rate: a color item needs one
// division and a feature item two; results are presented on the item marked
// last and sit in an output register, so the block keeps working while one
// waits. Configuration must be written by the user only while idle, unchecked.
module nlmeans_pair_weight_terms_unit
  import nlpw_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_val_p,
  input  logic [31:0] in_val_q,
  input  logic [30:0] in_var_p,
  input  logic [30:0] in_var_q,
  input  logic [30:0] in_gradient,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_color_term,
  output logic [31:0] out_feature_r,
  output logic [31:0] out_feature_b
);

  cfg_t   cfg_r;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kc    <= 31'd4194304;
      cfg_r.kf    <= 31'd377487;
      cfg_r.tau_r <= 31'd1049;
      cfg_r.tau_b <= 31'd105;
      cfg_r.eps   <= 31'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KC:  cfg_r.kc    <= cfg_data;
        REG_KF:  cfg_r.kf    <= cfg_data;
        REG_TR:  cfg_r.tau_r <= cfg_data;
        REG_TB:  cfg_r.tau_b <= cfg_data;
        REG_EPS: cfg_r.eps   <= cfg_data;
        default: ;
      endcase
    end
  end

  nlpw_fe #(.FRAC_BITS(FRAC_BITS)) u_fe (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_val_p    (in_val_p),
    .in_val_q    (in_val_q),
    .in_var_p    (in_var_p),
    .in_var_q    (in_var_q),
    .in_gradient (in_gradient),
    .in_last     (in_last),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  nlpw_q u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  nlpw_be #(.FRAC_BITS(FRAC_BITS)) u_be (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_color_term (out_color_term),
    .out_feature_r  (out_feature_r),
    .out_feature_b  (out_feature_b)
  );

endmodule

/* dv/nlmeans_pair_weight_terms_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlmeans_pair_weight_terms_unit_test
// Streams color and feature items through the pair weight unit, predicts the
// three dissimilarity terms of every pair and compares each emitted result.
// ----------------------------------------------------------------------------
module nlmeans_pair_weight_terms_unit_test
  import nlpw_pkg::*;
;

  localparam int FRAC = 20;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int LIMIT_CYCLES = 1500000;

  typedef struct {
    logic        rtype;
    logic [31:0] vp_sig;
    logic [31:0] vq_sig;
    logic [30:0] varp;
    logic [30:0] varq;
    logic [30:0] grad;
    logic        lst;
    logic        known;
    logic [31:0] k_color;
    logic [31:0] k_fr;
    logic [31:0] k_fb;
  } stim_row_t;

  typedef struct {
    logic [31:0] color;
    logic [31:0] fr;
    logic [31:0] fb;
  } terms_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [31:0] in_val_p;
  logic [31:0] in_val_q;
  logic [30:0] in_var_p;
  logic [30:0] in_var_q;
  logic [30:0] in_gradient;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_color_term;
  logic [31:0] out_feature_r;
  logic [31:0] out_feature_b;

  nlmeans_pair_weight_terms_unit #(.FRAC_BITS(FRAC)) DUT (.*);

  // Predictor copy of the registers and the per-pair accumulators.
  logic [30:0] m_kc, m_kf, m_tau_r, m_tau_b, m_eps;
  longint      acc_color, acc_min_r, acc_min_b;
  terms_t      pending_terms[$];
  logic        typed_known[$];
  terms_t      typed_terms[$];
  int          errors;
  longint      cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL nlmeans_pair_weight_terms_unit");
      $finish;
    end
  end

  function automatic longint sat_quotient(longint num, longint unsigned den);
    logic             neg;
    longint unsigned  mag, q, r;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    if (mag == 0) return 0;
    if (den == 0) return neg ? S32_MIN : S32_MAX;
    q = mag / den;
    r = mag % den;
    if (q >= (64'd1 << (32 - FRAC))) return neg ? S32_MIN : S32_MAX;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    if (neg) return (q > 64'd2147483648) ? S32_MIN : -longint'(q);
    return (q > 64'd2147483647) ? S32_MAX : longint'(q);
  endfunction

  // Folds one item into the pair state; returns 1 with the terms on a last item.
  function automatic bit fold_item(input logic rtype, input logic [31:0] vps,
                                   input logic [31:0] vqs, input logic [30:0] varp,
                                   input logic [30:0] varq, input logic [30:0] grad,
                                   input logic lst, output terms_t t);
    longint          diff, num, s, fr, fb;
    longint unsigned mag, sq, vmin, vmax, nr, nb, den;
    diff = longint'($signed(vps)) - longint'($signed(vqs));
    mag = diff < 0 ? -diff : diff;
    sq = (mag * mag) >> FRAC;
    vmin = (varp < varq) ? varp : varq;
    num = longint'(varp + vmin) - longint'(sq);
    if (rtype == TYPE_COLOR) begin
      den = m_eps + ((64'(m_kc) * (64'(varp) + varq)) >> FRAC);
      s = acc_color + sat_quotient(num, den);
      acc_color = s > S32_MAX ? S32_MAX : (s < S32_MIN ? S32_MIN : s);
    end else begin
      vmax = (varp > grad) ? varp : grad;
      nr = (m_tau_r > vmax) ? m_tau_r : vmax;
      nb = (m_tau_b > vmax) ? m_tau_b : vmax;
      fr = sat_quotient(num, (64'(m_kf) * nr) >> FRAC);
      fb = sat_quotient(num, (64'(m_kf) * nb) >> FRAC);
      if (fr < acc_min_r) acc_min_r = fr;
      if (fb < acc_min_b) acc_min_b = fb;
    end
    t.color = acc_color[31:0];
    t.fr = acc_min_r[31:0];
    t.fb = acc_min_b[31:0];
    if (!lst) return 0;
    acc_color = 0;
    acc_min_r = 0;
    acc_min_b = 0;
    return 1;
  endfunction

  // Receiver: stalls at random outside a cycling stall-free window, compares accepted results.
  logic [7:0] stall_phase;
  always @(posedge clk) begin
    terms_t want;
    logic   known;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_phase <= 8'd0;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase[7:6] == 2'd0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
      if (out_valid && !out_stall) begin
        if (pending_terms.size() == 0) begin
          $display("%0t: result with none expected: %h %h %h", $time,
                   out_color_term, out_feature_r, out_feature_b);
          errors++;
        end else begin
          want = pending_terms.pop_front();
          known = typed_known.pop_front();
          if (known) want = typed_terms.pop_front();
          if (out_color_term !== want.color) begin
            $display("%0t: color_term expected %h actual %h", $time, want.color,
                     out_color_term);
            errors++;
          end
          if (out_feature_r !== want.fr) begin
            $display("%0t: feature_r expected %h actual %h", $time, want.fr,
                     out_feature_r);
            errors++;
          end
          if (out_feature_b !== want.fb) begin
            $display("%0t: feature_b expected %h actual %h", $time, want.fb,
                     out_feature_b);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KC:  m_kc = val;
      REG_KF:  m_kf = val;
      REG_TR:  m_tau_r = val;
      REG_TB:  m_tau_b = val;
      REG_EPS: m_eps = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_pairs();
    int n;
    n = 0;
    while (pending_terms.size() != 0) @(posedge clk);
    // A trailing item without a last mark may still be in the divider.
    while (n < 200) begin
      @(posedge clk);
      n++;
    end
  endtask

  int burst_left;

  // Sender with bursts and gaps; a held valid stays high with no rewrite.
  task automatic send_item(input logic rtype, input logic [31:0] vps,
                           input logic [31:0] vqs, input logic [30:0] varp,
                           input logic [30:0] varq, input logic [30:0] grad,
                           input logic lst, input logic known,
                           input terms_t typed);
    terms_t t;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= rtype;
    in_val_p <= vps;
    in_val_q <= vqs;
    in_var_p <= varp;
    in_var_q <= varq;
    in_gradient <= grad;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_item(rtype, vps, vqs, varp, varq, grad, lst, t)) begin
      pending_terms.push_back(t);
      typed_known.push_back(known);
      if (known) typed_terms.push_back(typed);
    end
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h3FFFFF) - 32'h200000;
      2: return {$urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 16'($urandom())};
      default: return $urandom_range(0, 32'h00200000);
    endcase
  endfunction

  function automatic logic [30:0] rnd_var();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 32'h00400000));
      2: return 31'($urandom_range(0, 2000));
      default: return 31'h7FFFFFFF - 31'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic idle_sender();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic random_pairs(input int count);
    int elems;
    for (int n = 0; n < count; n++) begin
      elems = $urandom_range(1, 5);
      for (int e = 0; e < elems; e++) begin
        send_item($urandom_range(0, 1), rnd_val(), rnd_val(), rnd_var(), rnd_var(),
                  rnd_var(), e == elems - 1, 1'b0, '{default: '0});
      end
    end
    // An unterminated tail keeps accumulating into the next pair.
    send_item(TYPE_FEAT, rnd_val(), rnd_val(), rnd_var(), rnd_var(), rnd_var(),
              1'b0, 1'b0, '{default: '0});
    idle_sender();
  endtask

  stim_row_t directed[] = '{
    // Identical inputs, zero variances: every numerator is zero.
    '{TYPE_COLOR, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
    // Large difference, zero variance: color denominator is epsilon alone.
    '{TYPE_COLOR, 32'h7FFFFFFF, 32'h80000000, 31'h0, 31'h0, 31'h0, 1'b1, 1'b1,
      32'h80000000, 32'h0, 32'h0},
    // Feature item with large difference goes to the negative limit.
    '{TYPE_FEAT, 32'h80000000, 32'h7FFFFFFF, 31'h0, 31'h0, 31'h0, 1'b1, 1'b1,
      32'h0, 32'h80000000, 32'h80000000},
    // Positive feature quotients never lower the minima below zero.
    '{TYPE_FEAT, 32'h0, 32'h0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b1,
      32'h0, 32'h0, 32'h0},
    '{TYPE_COLOR, 32'h00100000, 32'h0, 31'h00100000, 31'h00080000, 31'h0, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{TYPE_FEAT, 32'h00300000, 32'hFFF00000, 31'h00010000, 31'h00200000, 31'h00040000,
      1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{TYPE_COLOR, 32'hFFFFFFFF, 32'h00000001, 31'h7FFFFFFF, 31'h0, 31'h0, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{TYPE_FEAT, 32'h00000400, 32'h0, 31'h0, 31'h0, 31'h00000001, 1'b1, 1'b0,
      32'h0, 32'h0, 32'h0},
    '{TYPE_COLOR, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
      1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
    '{TYPE_COLOR, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
      1'b1, 1'b0, 32'h0, 32'h0, 32'h0},
    '{TYPE_FEAT, 32'h00000800, 32'h0, 31'h5, 31'h7, 31'h3, 1'b1, 1'b0,
      32'h0, 32'h0, 32'h0}
  };

  initial begin
    terms_t t;
    errors = 0;
    cycle_count = 0;
    burst_left = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KC;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_type = TYPE_COLOR;
    in_val_p = '0;
    in_val_q = '0;
    in_var_p = '0;
    in_var_q = '0;
    in_gradient = '0;
    in_last = 1'b0;
    m_kc = 31'd4194304;
    m_kf = 31'd377487;
    m_tau_r = 31'd1049;
    m_tau_b = 31'd105;
    m_eps = 31'd1;
    acc_color = 0;
    acc_min_r = 0;
    acc_min_b = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      t.color = directed[i].k_color;
      t.fr = directed[i].k_fr;
      t.fb = directed[i].k_fb;
      send_item(directed[i].rtype, directed[i].vp_sig, directed[i].vq_sig,
                directed[i].varp, directed[i].varq, directed[i].grad,
                directed[i].lst, directed[i].known, t);
    end
    idle_sender();
    drain_pairs();

    random_pairs(110);
    drain_pairs();

    // Zero sensitivities force zero feature denominators; largest tau_r floor, tau_b floor of one.
    write_reg(REG_KC, 31'h0);
    write_reg(REG_KF, 31'h0);
    write_reg(REG_TR, 31'h7FFFFFFF);
    write_reg(REG_TB, 31'h1);
    write_reg(REG_EPS, 31'h7FFFFFFF);
    random_pairs(70);
    drain_pairs();

    write_reg(REG_KC, 31'h7FFFFFFF);
    write_reg(REG_KF, 31'h7FFFFFFF);
    write_reg(REG_TR, 31'h1);
    write_reg(REG_TB, 31'h7FFFFFFF);
    write_reg(REG_EPS, 31'h0);
    random_pairs(70);
    drain_pairs();

    for (int k = 0; k < 3; k++) begin
      write_reg(REG_KC, 31'($urandom()) >> $urandom_range(0, 20));
      write_reg(REG_KF, 31'($urandom()) >> $urandom_range(0, 20));
      write_reg(REG_TR, 31'($urandom()) >> $urandom_range(0, 30));
      write_reg(REG_TB, 31'($urandom()) >> $urandom_range(0, 30));
      write_reg(REG_EPS, 31'($urandom()) >> $urandom_range(0, 30));
      random_pairs(40);
      drain_pairs();
    end

    if (errors == 0) begin
      $display("PASS nlmeans_pair_weight_terms_unit");
    end else begin
      $display("FAIL nlmeans_pair_weight_terms_unit");
    end
    $finish;
  end

endmodule
